/* design/kvt_pkg.sv */
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCNT_W   = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [DATA_W-1:0]  key;
        logic signed [DATA_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic                      found;
        logic signed [DATA_W-1:0]  value_out;
        logic                      full_refused;
        logic [OCNT_W-1:0]         entry_count;
        logic                      is_empty;
    } t_out_item;

endpackage

/* design/kvt_ram.sv */
`timescale 1ns / 1ps

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/key_value_table.sv */
`timescale 1ns / 1ps

// channel   ports                 handshake
// -------   -------------------   -------------------------------------------
// input     i_item, start, busy   item taken at a clock edge with start && !busy
// result    o_item, o_done        item shown for one cycle while o_done is high
//
// each item is handled in steps: the key and value memories are read one
// slot a cycle, the last slot is compared after its read, ST_FIN writes
// back, and the result is shown in the cycle after that.
// busy is high from the accepting edge until the result is shown; start is
// taken again in the cycle the result is shown. reset clears the slot valid
// bits and the entry count at once. the receiver cannot stall.

module key_value_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  kvt_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_done,
    output kvt_pkg::t_out_item  o_item
);

    localparam int IW = kvt_pkg::IDX_W;
    localparam int CW = kvt_pkg::CNT_W;
    localparam int DW = kvt_pkg::DATA_W;

    kvt_pkg::t_state   r_state, n_state;
    kvt_pkg::t_in_item r_in;
    logic [CW-1:0]     r_addr;
    logic              r_chk;
    logic [IW-1:0]     r_chk_idx;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    logic [DW-1:0]     r_old;
    logic              r_free_ok;
    logic [IW-1:0]     r_free_idx;
    logic [CW-1:0]     r_count, n_count;
    logic              r_valid [kvt_pkg::CAPACITY];
    logic              r_done;
    kvt_pkg::t_out_item r_out, n_out;

    logic              rd_en;
    logic [DW-1:0]     rd_key, rd_value;
    logic              key_we, val_we;
    logic [IW-1:0]     wr_idx;
    logic              set_valid, clr_valid;
    logic              match, empty_slot;

    assign rd_en = (r_state == kvt_pkg::ST_SCAN) && (r_addr < CW'(kvt_pkg::CAPACITY));

    kvt_ram #(.WIDTH(DW), .DEPTH(kvt_pkg::CAPACITY)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (wr_idx),
        .i_wdata (r_in.key),
        .i_re    (rd_en),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (rd_key)
    );

    kvt_ram #(.WIDTH(DW), .DEPTH(kvt_pkg::CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (wr_idx),
        .i_wdata (r_in.value),
        .i_re    (rd_en),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (rd_value)
    );

    assign match      = r_chk && r_valid[r_chk_idx] && (rd_key == r_in.key);
    assign empty_slot = r_chk && !r_valid[r_chk_idx];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_out     = r_out;
        key_we    = 1'b0;
        val_we    = 1'b0;
        wr_idx    = r_hit_idx;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        unique case (r_state)
            kvt_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = kvt_pkg::ST_SCAN;
                end
            end
            kvt_pkg::ST_SCAN: begin
                if (r_chk && (r_chk_idx == IW'(kvt_pkg::CAPACITY - 1))) begin
                    n_state = kvt_pkg::ST_FIN;
                end
            end
            kvt_pkg::ST_FIN: begin
                n_state            = kvt_pkg::ST_IDLE;
                n_out.found        = 1'b0;
                n_out.value_out    = '0;
                n_out.full_refused = 1'b0;
                unique case (r_in.cmd)
                    kvt_pkg::CMD_INSERT: begin
                        n_out.found     = r_hit;
                        n_out.value_out = r_hit ? r_old : '0;
                        if (r_hit) begin
                            val_we = 1'b1;
                        end else if (r_free_ok) begin
                            wr_idx    = r_free_idx;
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            set_valid = 1'b1;
                            n_count   = r_count + CW'(1);
                        end else begin
                            n_out.full_refused = 1'b1;
                        end
                    end
                    kvt_pkg::CMD_LOOKUP: begin
                        n_out.found     = r_hit;
                        n_out.value_out = r_hit ? r_old : '0;
                    end
                    kvt_pkg::CMD_REMOVE: begin
                        n_out.found     = r_hit;
                        n_out.value_out = r_hit ? r_old : '0;
                        if (r_hit) begin
                            clr_valid = 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_out.entry_count = kvt_pkg::OCNT_W'(n_count);
                n_out.is_empty    = (n_count == '0);
            end
            default: begin
                n_state = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
            r_chk   <= 1'b0;
            r_hit   <= 1'b0;
            r_free_ok <= 1'b0;
            r_addr  <= '0;
            for (int i = 0; i < kvt_pkg::CAPACITY; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_count <= n_count;
            r_done  <= (r_state == kvt_pkg::ST_FIN);
            if (set_valid) begin
                r_valid[wr_idx] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[wr_idx] <= 1'b0;
            end
            if ((r_state == kvt_pkg::ST_IDLE) && start) begin
                r_addr    <= '0;
                r_chk     <= 1'b0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (r_state == kvt_pkg::ST_SCAN) begin
                r_chk <= rd_en;
                if (rd_en) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (empty_slot && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end else begin
                r_chk <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == kvt_pkg::ST_IDLE) && start) begin
            r_in <= i_item;
        end
        if (rd_en) begin
            r_chk_idx <= r_addr[IW-1:0];
        end
        if ((r_state == kvt_pkg::ST_SCAN) && match && !r_hit) begin
            r_hit_idx <= r_chk_idx;
            r_old     <= rd_value;
        end
        if ((r_state == kvt_pkg::ST_SCAN) && empty_slot && !r_free_ok) begin
            r_free_idx <= r_chk_idx;
        end
        r_out <= n_out;
    end

    assign busy   = (r_state != kvt_pkg::ST_IDLE);
    assign o_done = r_done;
    assign o_item = r_out;

endmodule
